// ===== rtl/thfc_pkg.sv =====
// ----------------------------------------------------------------------------
// thfc_pkg
// Shared types and constants for the turn and hazard flasher controller.
// ----------------------------------------------------------------------------
package thfc_pkg;

	localparam int CUR_W     = 12;
	localparam int CNT_W     = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 12;

	typedef enum logic [1:0] {
		MODE_OFF    = 2'd0,
		MODE_HAZARD = 2'd1,
		MODE_LEFT   = 2'd2,
		MODE_RIGHT  = 2'd3
	} mode_t;

	// lamp health class, also the fault event code
	localparam logic [1:0] FAULT_NONE  = 2'd0;
	localparam logic [1:0] FAULT_OPEN  = 2'd1;
	localparam logic [1:0] FAULT_SHORT = 2'd2;

	localparam logic [1:0] BAT_NORMAL = 2'd0;
	localparam logic [1:0] BAT_OVER   = 2'd1;
	localparam logic [1:0] BAT_UNDER  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_PERIOD   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FAST_PERIOD     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_THRESHOLD  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_THRESHOLD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_BLINKS      = 3'd4;

	localparam logic [CNT_W-1:0] RST_NORMAL_PERIOD   = 8'd40;
	localparam logic [CNT_W-1:0] RST_FAST_PERIOD     = 8'd20;
	localparam logic [CUR_W-1:0] RST_OPEN_THRESHOLD  = 12'd620;
	localparam logic [CUR_W-1:0] RST_SHORT_THRESHOLD = 12'd2482;
	localparam logic [CNT_W-1:0] RST_MIN_BLINKS      = 8'd3;

	localparam logic [CNT_W-1:0] BLINK_MAX = 8'd255;

endpackage

// ===== rtl/turn_hazard_flasher_controller.sv =====
// ----------------------------------------------------------------------------
// turn_hazard_flasher_controller
// Turn and hazard lamp flasher: mode machine, blink timer, lamp fault checks.
// ----------------------------------------------------------------------------
// One item is one control tick. The block takes an item in every cycle
// while the output is not stalled. The item is registered, the whole mode,
// timer and fault update runs as combinational logic, and the result lands
// in an output register. Sustained rate is one item per cycle while the
// output does not stall; a stalled output holds the output register and the
// state, and through in_stall the input register. Configuration writes are
// always ready and take effect at once.
module turn_hazard_flasher_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            left_switch,
	input  logic                            right_switch,
	input  logic                            hazard_switch,
	input  logic [thfc_pkg::CUR_W-1:0]      left_current,
	input  logic [thfc_pkg::CUR_W-1:0]      right_current,
	input  logic [1:0]                      battery_state,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            left_lamp,
	output logic                            right_lamp,
	output logic [1:0]                      left_fault_event,
	output logic [1:0]                      right_fault_event,
	output logic [1:0]                      mode,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [thfc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [thfc_pkg::CFG_DAT_W-1:0]  cfg_data
);
	import thfc_pkg::*;

	// configuration
	logic [CNT_W-1:0] normal_period_q, fast_period_q, min_blinks_q;
	logic [CUR_W-1:0] open_th_q, short_th_q;

	// input register
	logic             valid_s1;
	logic             l_s1, r_s1, h_s1;
	logic [CUR_W-1:0] lc_s1, rc_s1;
	logic [1:0]       bat_s1;

	// result register
	logic             out_valid_s2;
	logic             left_lamp_s2, right_lamp_s2;
	logic [1:0]       lev_s2, rev_s2;
	logic [1:0]       mode_s2;

	// controller state
	mode_t            cm_q, rm_q;
	logic [1:0]       lamps_q, fr_q, wr_q;
	logic             htp_q, fb_q;
	logic [CNT_W-1:0] bt_q, bc_q;
	logic [2:0]       sh_q;

	// next state
	mode_t            cm_d, rm_d;
	logic [1:0]       lamps_d, fr_d, wr_d;
	logic             htp_d, fb_d;
	logic [CNT_W-1:0] bt_d, bc_d;
	logic [2:0]       sh_d;
	logic [1:0]       lev_d, rev_d;

	// result fields
	logic             res_left_lamp, res_right_lamp;
	logic [1:0]       res_lev, res_rev, res_mode;

	logic             accept, adv;
	logic [CNT_W-1:0] per, t_inc, t_next;
	logic             t_exp;
	logic [1:0]       lcl, rcl;
	logic             wl, wrr;

	assign adv      = valid_s1 && (!out_valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// blink timer step, used only in the blinking modes
	assign per    = fb_q ? fast_period_q : normal_period_q;
	assign t_inc  = bt_q + 8'd1;
	assign t_exp  = (t_inc >= per);
	assign t_next = t_exp ? '0 : t_inc;

	assign lcl = (lc_s1 < open_th_q) ? FAULT_OPEN :
	             (lc_s1 > short_th_q) ? FAULT_SHORT : FAULT_NONE;
	assign rcl = (rc_s1 < open_th_q) ? FAULT_OPEN :
	             (rc_s1 > short_th_q) ? FAULT_SHORT : FAULT_NONE;

	// next-state logic
	always_comb begin
		cm_d    = cm_q;
		rm_d    = rm_q;
		lamps_d = lamps_q;
		fr_d    = fr_q;
		wr_d    = wr_q;
		htp_d   = htp_q;
		fb_d    = fb_q;
		bt_d    = bt_q;
		bc_d    = bc_q;
		lev_d   = FAULT_NONE;
		rev_d   = FAULT_NONE;

		if (!sh_q[2] && h_s1)
			htp_d = 1'b1;
		sh_d = {h_s1, r_s1, l_s1};

		if (sh_q[0] && !l_s1)
			wr_d[0] = 1'b0;
		if (sh_q[1] && !r_s1)
			wr_d[1] = 1'b0;
		wl  = wr_d[0];
		wrr = wr_d[1];

		unique case (cm_q)
			MODE_OFF: begin
				lamps_d = 2'b00;
				unique case (rm_q)
					MODE_OFF: begin
						if (l_s1 && !wl)
							cm_d = MODE_LEFT;
						else if (r_s1 && !wrr)
							cm_d = MODE_RIGHT;
						else if (htp_d) begin
							htp_d = 1'b0;
							cm_d  = MODE_HAZARD;
						end
					end
					MODE_HAZARD: begin
						if (l_s1)
							cm_d = MODE_LEFT;
						else if (r_s1)
							cm_d = MODE_RIGHT;
						else begin
							cm_d = MODE_HAZARD;
							rm_d = MODE_OFF;
						end
					end
					MODE_LEFT: begin
						if (r_s1)
							cm_d = MODE_RIGHT;
						else if (htp_d) begin
							htp_d = 1'b0;
							cm_d  = MODE_HAZARD;
						end else begin
							cm_d = MODE_LEFT;
							rm_d = MODE_OFF;
						end
					end
					MODE_RIGHT: begin
						if (l_s1)
							cm_d = MODE_LEFT;
						else if (htp_d) begin
							htp_d = 1'b0;
							cm_d  = MODE_HAZARD;
						end else begin
							cm_d = MODE_RIGHT;
							rm_d = MODE_OFF;
						end
					end
					default: ;
				endcase
			end
			MODE_HAZARD: begin
				bt_d = t_next;
				if (t_exp) begin
					lamps_d = lamps_q ^ 2'b11;
					if (lamps_d[0] && bc_q != BLINK_MAX)
						bc_d = bc_q + 8'd1;
				end
				if (rm_q == MODE_OFF) begin
					if (htp_d && bc_d > min_blinks_q) begin
						htp_d = 1'b0;
						bc_d  = '0;
						cm_d  = MODE_OFF;
					end else if ((l_s1 && !wl) || (r_s1 && !wrr)) begin
						bc_d = '0;
						cm_d = MODE_OFF;
						rm_d = MODE_HAZARD;
					end
				end else if (htp_d) begin
					htp_d = 1'b0;
					cm_d  = MODE_OFF;
				end
			end
			MODE_LEFT: begin
				bt_d = t_next;
				if (t_exp) begin
					lamps_d[0] = !lamps_q[0];
					if (lamps_d[0] && bc_q != BLINK_MAX)
						bc_d = bc_q + 8'd1;
				end
				lamps_d[1] = 1'b0;
				if (rm_q == MODE_OFF) begin
					if (!l_s1 && bc_d > min_blinks_q) begin
						bc_d = '0;
						cm_d = MODE_OFF;
					end else if ((r_s1 && !wrr) || htp_d) begin
						bc_d = '0;
						cm_d = MODE_OFF;
						rm_d = MODE_LEFT;
					end
				end else if (!l_s1) begin
					bc_d = '0;
					cm_d = MODE_OFF;
				end
			end
			MODE_RIGHT: begin
				bt_d = t_next;
				if (t_exp) begin
					lamps_d[1] = !lamps_q[1];
					if (lamps_d[1] && bc_q != BLINK_MAX)
						bc_d = bc_q + 8'd1;
				end
				lamps_d[0] = 1'b0;
				if (rm_q == MODE_OFF) begin
					if (!r_s1 && bc_d > min_blinks_q) begin
						bc_d = '0;
						cm_d = MODE_OFF;
					end else if ((l_s1 && !wl) || htp_d) begin
						bc_d = '0;
						cm_d = MODE_OFF;
						rm_d = MODE_RIGHT;
					end
				end else if (!r_s1) begin
					bc_d = '0;
					cm_d = MODE_OFF;
				end
			end
			default: ;
		endcase

		// lamp health and battery are skipped while hazard runs
		if (cm_d != MODE_HAZARD) begin
			// both shorted leaves the period as it is
			if (lcl == FAULT_OPEN || rcl == FAULT_OPEN)
				fb_d = 1'b1;
			else if (lcl == FAULT_NONE || rcl == FAULT_NONE)
				fb_d = 1'b0;

			if (lcl != FAULT_NONE) begin
				if (lcl == FAULT_SHORT) begin
					lamps_d[0] = 1'b0;
					cm_d       = MODE_OFF;
					rm_d       = MODE_OFF;
					wr_d[0]    = 1'b1;
				end
				if (!fr_d[0]) begin
					fr_d[0] = 1'b1;
					lev_d   = lcl;
				end
			end else begin
				fr_d[0] = 1'b0;
			end

			if (rcl != FAULT_NONE) begin
				if (rcl == FAULT_SHORT) begin
					lamps_d[1] = 1'b0;
					cm_d       = MODE_OFF;
					rm_d       = MODE_OFF;
					wr_d[1]    = 1'b1;
				end
				if (!fr_d[1]) begin
					fr_d[1] = 1'b1;
					rev_d   = rcl;
				end
			end else begin
				fr_d[1] = 1'b0;
			end

			// reserved battery code counts as normal
			if (bat_s1 == BAT_OVER) begin
				lamps_d = 2'b00;
			end else if (bat_s1 == BAT_UNDER) begin
				lamps_d = 2'b00;
				cm_d    = MODE_OFF;
				rm_d    = MODE_OFF;
				wr_d    = 2'b11;
			end
		end
	end

	// result fields
	always_comb begin
		res_left_lamp  = lamps_d[0];
		res_right_lamp = lamps_d[1];
		res_lev        = lev_d;
		res_rev        = rev_d;
		res_mode       = cm_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_period_q <= RST_NORMAL_PERIOD;
			fast_period_q   <= RST_FAST_PERIOD;
			open_th_q       <= RST_OPEN_THRESHOLD;
			short_th_q      <= RST_SHORT_THRESHOLD;
			min_blinks_q    <= RST_MIN_BLINKS;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_NORMAL_PERIOD:   normal_period_q <= cfg_data[CNT_W-1:0];
				CFG_FAST_PERIOD:     fast_period_q   <= cfg_data[CNT_W-1:0];
				CFG_OPEN_THRESHOLD:  open_th_q       <= cfg_data[CUR_W-1:0];
				CFG_SHORT_THRESHOLD: short_th_q      <= cfg_data[CUR_W-1:0];
				CFG_MIN_BLINKS:      min_blinks_q    <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else begin
			valid_s1     <= accept || (valid_s1 && !adv);
			out_valid_s2 <= adv || (out_valid_s2 && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			l_s1   <= left_switch;
			r_s1   <= right_switch;
			h_s1   <= hazard_switch;
			lc_s1  <= left_current;
			rc_s1  <= right_current;
			bat_s1 <= battery_state;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			left_lamp_s2  <= res_left_lamp;
			right_lamp_s2 <= res_right_lamp;
			lev_s2        <= res_lev;
			rev_s2        <= res_rev;
			mode_s2       <= res_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cm_q    <= MODE_OFF;
			rm_q    <= MODE_OFF;
			lamps_q <= 2'b00;
			htp_q   <= 1'b0;
			bt_q    <= '0;
			bc_q    <= '0;
			fr_q    <= 2'b00;
			wr_q    <= 2'b00;
			fb_q    <= 1'b0;
			sh_q    <= 3'b000;
		end else if (adv) begin
			cm_q    <= cm_d;
			rm_q    <= rm_d;
			lamps_q <= lamps_d;
			htp_q   <= htp_d;
			bt_q    <= bt_d;
			bc_q    <= bc_d;
			fr_q    <= fr_d;
			wr_q    <= wr_d;
			fb_q    <= fb_d;
			sh_q    <= sh_d;
		end
	end

	assign out_valid         = out_valid_s2;
	assign left_lamp         = left_lamp_s2;
	assign right_lamp        = right_lamp_s2;
	assign left_fault_event  = lev_s2;
	assign right_fault_event = rev_s2;
	assign mode              = mode_s2;

endmodule

// ===== rtl/thfc_checker.sv =====
// ----------------------------------------------------------------------------
// thfc_checker
// Port-level checks for the turn and hazard flasher controller.
// ----------------------------------------------------------------------------
module thfc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic                            left_lamp,
	input logic                            right_lamp,
	input logic [1:0]                      left_fault_event,
	input logic [1:0]                      right_fault_event,
	input logic [1:0]                      mode
);
	import thfc_pkg::*;

	// a held result item keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(mode) && $stable(left_lamp)
			&& $stable(right_lamp) && $stable(left_fault_event)
			&& $stable(right_fault_event))
		else $error("result item changed while stalled");

	// a turn mode never lights the opposite lamp
	a_turn_side: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(mode == MODE_LEFT && right_lamp) && !(mode == MODE_RIGHT && left_lamp))
		else $error("opposite lamp lit in turn mode");

	// a shorted lamp is reported with its drive off
	a_short_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(left_fault_event == FAULT_SHORT && left_lamp)
			&& !(right_fault_event == FAULT_SHORT && right_lamp))
		else $error("shorted lamp still driven");

	// no fault report while hazard runs, and no undefined event code
	a_fault_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> left_fault_event != 2'd3 && right_fault_event != 2'd3
			&& !(mode == MODE_HAZARD && (left_fault_event != FAULT_NONE
				|| right_fault_event != FAULT_NONE)))
		else $error("bad fault event");

endmodule

bind turn_hazard_flasher_controller thfc_checker u_thfc_checker (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the turn and hazard flasher controller. A
// cycle-accurate lamp predictor runs on every accepted tick and its results
// are compared in order with the block's output items. Directed sequences
// cover period changes, blink count saturation and the fault and battery
// corner cases. Random switch runs then follow under several idle and stall
// patterns.
// ----------------------------------------------------------------------------
module tb_top;
	import thfc_pkg::*;

	localparam logic [1:0] BAT_RESERVED   = 2'd3;
	localparam int         WATCHDOG_LIMIT = 2000;
	localparam int         HOLD_CYCLES    = 80;

	typedef struct packed {
		logic              left_sw;
		logic              right_sw;
		logic              haz_sw;
		logic [CUR_W-1:0]  left_cur;
		logic [CUR_W-1:0]  right_cur;
		logic [1:0]        battery;
	} tick_t;

	typedef struct packed {
		logic       left_lamp;
		logic       right_lamp;
		logic [1:0] left_event;
		logic [1:0] right_event;
		mode_t      mode;
	} lamp_status_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 left_switch = 1'b0;
	logic                 right_switch = 1'b0;
	logic                 hazard_switch = 1'b0;
	logic [CUR_W-1:0]     left_current = '0;
	logic [CUR_W-1:0]     right_current = '0;
	logic [1:0]           battery_state = BAT_NORMAL;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 left_lamp;
	logic                 right_lamp;
	logic [1:0]           left_fault_event;
	logic [1:0]           right_fault_event;
	logic [1:0]           mode;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	turn_hazard_flasher_controller u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.left_switch       (left_switch),
		.right_switch      (right_switch),
		.hazard_switch     (hazard_switch),
		.left_current      (left_current),
		.right_current     (right_current),
		.battery_state     (battery_state),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.left_lamp         (left_lamp),
		.right_lamp        (right_lamp),
		.left_fault_event  (left_fault_event),
		.right_fault_event (right_fault_event),
		.mode              (mode),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor configuration and state
	logic [CNT_W-1:0] norm_per, fast_per, min_blk;
	logic [CUR_W-1:0] open_thr, short_thr;
	mode_t            cur_mode, prev_mode;
	logic [1:0]       lamp_on, fault_seen, wait_rel;
	logic             haz_pend, fast_sel;
	logic [CNT_W-1:0] blink_tmr, blink_cnt;
	logic [2:0]       sw_hist;

	lamp_status_t pending_status[$];
	int           items_sent = 0;
	int           results_seen = 0;
	int           fail_count = 0;
	int           idle_pct = 0;
	int           stall_pct = 0;
	bit           hold_req = 1'b0;
	int           hold_left = 0;
	int           quiet_cycles = 0;

	function automatic void reset_model();
		norm_per   = RST_NORMAL_PERIOD;
		fast_per   = RST_FAST_PERIOD;
		open_thr   = RST_OPEN_THRESHOLD;
		short_thr  = RST_SHORT_THRESHOLD;
		min_blk    = RST_MIN_BLINKS;
		cur_mode   = MODE_OFF;
		prev_mode  = MODE_OFF;
		lamp_on    = 2'b00;
		fault_seen = 2'b00;
		wait_rel   = 2'b00;
		haz_pend   = 1'b0;
		fast_sel   = 1'b0;
		blink_tmr  = '0;
		blink_cnt  = '0;
		sw_hist    = 3'b000;
	endfunction

	function automatic logic [1:0] lamp_class(logic [CUR_W-1:0] cur);
		if (cur < open_thr)
			return FAULT_OPEN;
		if (cur > short_thr)
			return FAULT_SHORT;
		return FAULT_NONE;
	endfunction

	// timer compare is >=, so a stale timer above a lowered period fires at once
	function automatic logic blink_due();
		logic [CNT_W-1:0] per;
		per = fast_sel ? fast_per : norm_per;
		blink_tmr = blink_tmr + 8'd1;
		if (blink_tmr >= per) begin
			blink_tmr = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void bump_blinks();
		if (blink_cnt != BLINK_MAX)
			blink_cnt = blink_cnt + 8'd1;
	endfunction

	function automatic logic [1:0] lamp_health(int unsigned side, logic [CUR_W-1:0] cur);
		logic [1:0] cls, bitm, ev;
		cls  = lamp_class(cur);
		bitm = 2'b01 << side;
		ev   = FAULT_NONE;
		if (cls != FAULT_NONE) begin
			if (cls == FAULT_SHORT) begin
				lamp_on   &= ~bitm;
				cur_mode  = MODE_OFF;
				prev_mode = MODE_OFF;
				wait_rel  |= bitm;
			end
			if ((fault_seen & bitm) == 2'b00) begin
				fault_seen |= bitm;
				ev = cls;
			end
		end else begin
			fault_seen &= ~bitm;
		end
		return ev;
	endfunction

	function automatic lamp_status_t next_lamp_status(tick_t t);
		logic         l_was, r_was, h_was, wl, wr, more;
		logic [1:0]   lcl, rcl, lev, rev;
		lamp_status_t res;
		l_was = sw_hist[0];
		r_was = sw_hist[1];
		h_was = sw_hist[2];
		lev   = FAULT_NONE;
		rev   = FAULT_NONE;
		if (!h_was && t.haz_sw)
			haz_pend = 1'b1;
		sw_hist = {t.haz_sw, t.right_sw, t.left_sw};
		if (l_was && !t.left_sw)
			wait_rel[0] = 1'b0;
		if (r_was && !t.right_sw)
			wait_rel[1] = 1'b0;
		wl = wait_rel[0];
		wr = wait_rel[1];

		case (cur_mode)
		MODE_OFF: begin
			lamp_on = 2'b00;
			case (prev_mode)
			MODE_OFF: begin
				if (t.left_sw && !wl) begin
					cur_mode = MODE_LEFT;
				end else if (t.right_sw && !wr) begin
					cur_mode = MODE_RIGHT;
				end else if (haz_pend) begin
					haz_pend = 1'b0;
					cur_mode = MODE_HAZARD;
				end
			end
			MODE_HAZARD: begin
				if (t.left_sw) begin
					cur_mode = MODE_LEFT;
				end else if (t.right_sw) begin
					cur_mode = MODE_RIGHT;
				end else begin
					cur_mode  = MODE_HAZARD;
					prev_mode = MODE_OFF;
				end
			end
			MODE_LEFT: begin
				if (t.right_sw) begin
					cur_mode = MODE_RIGHT;
				end else if (haz_pend) begin
					haz_pend = 1'b0;
					cur_mode = MODE_HAZARD;
				end else begin
					cur_mode  = MODE_LEFT;
					prev_mode = MODE_OFF;
				end
			end
			default: begin
				if (t.left_sw) begin
					cur_mode = MODE_LEFT;
				end else if (haz_pend) begin
					haz_pend = 1'b0;
					cur_mode = MODE_HAZARD;
				end else begin
					cur_mode  = MODE_RIGHT;
					prev_mode = MODE_OFF;
				end
			end
			endcase
		end
		MODE_HAZARD: begin
			if (blink_due()) begin
				lamp_on ^= 2'b11;
				if (lamp_on[0])
					bump_blinks();
			end
			more = blink_cnt > min_blk;
			if (prev_mode == MODE_OFF) begin
				if (haz_pend && more) begin
					haz_pend  = 1'b0;
					blink_cnt = '0;
					cur_mode  = MODE_OFF;
				end else if ((t.left_sw && !wl) || (t.right_sw && !wr)) begin
					blink_cnt = '0;
					cur_mode  = MODE_OFF;
					prev_mode = MODE_HAZARD;
				end
			end else if (haz_pend) begin
				haz_pend = 1'b0;
				cur_mode = MODE_OFF;
			end
		end
		MODE_LEFT: begin
			if (blink_due()) begin
				lamp_on ^= 2'b01;
				if (lamp_on[0])
					bump_blinks();
			end
			lamp_on &= 2'b01;
			more = blink_cnt > min_blk;
			if (prev_mode == MODE_OFF) begin
				if (!t.left_sw && more) begin
					blink_cnt = '0;
					cur_mode  = MODE_OFF;
				end else if ((t.right_sw && !wr) || haz_pend) begin
					blink_cnt = '0;
					cur_mode  = MODE_OFF;
					prev_mode = MODE_LEFT;
				end
			end else if (!t.left_sw) begin
				blink_cnt = '0;
				cur_mode  = MODE_OFF;
			end
		end
		default: begin
			if (blink_due()) begin
				lamp_on ^= 2'b10;
				if (lamp_on[1])
					bump_blinks();
			end
			lamp_on &= 2'b10;
			more = blink_cnt > min_blk;
			if (prev_mode == MODE_OFF) begin
				if (!t.right_sw && more) begin
					blink_cnt = '0;
					cur_mode  = MODE_OFF;
				end else if ((t.left_sw && !wl) || haz_pend) begin
					blink_cnt = '0;
					cur_mode  = MODE_OFF;
					prev_mode = MODE_RIGHT;
				end
			end else if (!t.right_sw) begin
				blink_cnt = '0;
				cur_mode  = MODE_OFF;
			end
		end
		endcase

		// hazard skips lamp health and battery handling entirely
		if (cur_mode != MODE_HAZARD) begin
			lcl = lamp_class(t.left_cur);
			rcl = lamp_class(t.right_cur);
			if (lcl == FAULT_OPEN || rcl == FAULT_OPEN)
				fast_sel = 1'b1;
			else if (lcl == FAULT_NONE || rcl == FAULT_NONE)
				fast_sel = 1'b0;
			lev = lamp_health(0, t.left_cur);
			rev = lamp_health(1, t.right_cur);
			if (t.battery == BAT_OVER) begin
				lamp_on = 2'b00;
			end else if (t.battery == BAT_UNDER) begin
				lamp_on   = 2'b00;
				cur_mode  = MODE_OFF;
				prev_mode = MODE_OFF;
				wait_rel  = 2'b11;
			end
		end

		res.left_lamp   = lamp_on[0];
		res.right_lamp  = lamp_on[1];
		res.left_event  = lev;
		res.right_event = rev;
		res.mode        = cur_mode;
		return res;
	endfunction

	task automatic check_field(input string name, input logic [1:0] exp_v, act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0d got %0d", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	// prediction on accepted items and config writes, in-order result check
	always @(posedge clk) begin : scoreboard
		lamp_status_t exp_r;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_NORMAL_PERIOD:   norm_per  = cfg_data[CNT_W-1:0];
				CFG_FAST_PERIOD:     fast_per  = cfg_data[CNT_W-1:0];
				CFG_OPEN_THRESHOLD:  open_thr  = cfg_data;
				CFG_SHORT_THRESHOLD: short_thr = cfg_data;
				CFG_MIN_BLINKS:      min_blk   = cfg_data[CNT_W-1:0];
				default: ;
				endcase
			end
			if (in_valid && !in_stall)
				pending_status.push_back(next_lamp_status({left_switch, right_switch,
					hazard_switch, left_current, right_current, battery_state}));
			if (out_valid && !out_stall) begin
				results_seen++;
				if (pending_status.size() == 0) begin
					$display("%0t: unexpected item, lamps %b%b mode %0d", $time,
						left_lamp, right_lamp, mode);
					fail_count++;
				end else begin
					exp_r = pending_status.pop_front();
					check_field("left_lamp", 2'(exp_r.left_lamp), 2'(left_lamp));
					check_field("right_lamp", 2'(exp_r.right_lamp), 2'(right_lamp));
					check_field("left_fault_event", exp_r.left_event, left_fault_event);
					check_field("right_fault_event", exp_r.right_event, right_fault_event);
					check_field("mode", exp_r.mode, mode);
				end
			end
		end
	end

	// output back-pressure, with an occasional long hold to fill the pipe
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	function automatic tick_t make_tick(logic l, r, h, logic [CUR_W-1:0] lc, rc, logic [1:0] bat);
		tick_t t;
		t.left_sw   = l;
		t.right_sw  = r;
		t.haz_sw    = h;
		t.left_cur  = lc;
		t.right_cur = rc;
		t.battery   = bat;
		return t;
	endfunction

	function automatic logic [CUR_W-1:0] pick_current();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 8 && open_thr != 0)
			return CUR_W'($urandom_range(open_thr - 1, 0));
		if (roll < 16 && short_thr != 12'hFFF)
			return CUR_W'($urandom_range(4095, short_thr + 1));
		if (roll < 22 || open_thr > short_thr)
			return CUR_W'($urandom_range(4095, 0));
		return CUR_W'($urandom_range(short_thr, open_thr));
	endfunction

	// caller sits at a rising edge; valid stays high when the next item follows
	task automatic send_tick(input tick_t t);
		in_valid      <= 1'b1;
		left_switch   <= t.left_sw;
		right_switch  <= t.right_sw;
		hazard_switch <= t.haz_sw;
		left_current  <= t.left_cur;
		right_current <= t.right_cur;
		battery_state <= t.battery;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (results_seen < items_sent)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic set_config(input logic [CNT_W-1:0] np, fp, input logic [CUR_W-1:0] ot, st,
			input logic [CNT_W-1:0] mb);
		write_reg(CFG_NORMAL_PERIOD, CFG_DAT_W'(np));
		write_reg(CFG_FAST_PERIOD, CFG_DAT_W'(fp));
		write_reg(CFG_OPEN_THRESHOLD, ot);
		write_reg(CFG_SHORT_THRESHOLD, st);
		write_reg(CFG_MIN_BLINKS, CFG_DAT_W'(mb));
		cfg_valid <= 1'b0;
	endtask

	// left mode at reset settings, then the period is lowered under a running timer and then set to zero
	task automatic test_period_change();
		idle_pct  = 7;
		stall_pct = 7;
		set_config(RST_NORMAL_PERIOD, RST_FAST_PERIOD, RST_OPEN_THRESHOLD,
			RST_SHORT_THRESHOLD, RST_MIN_BLINKS);
		repeat (12)
			send_tick(make_tick(1, 0, 0, 1000, 1000, BAT_NORMAL));
		wait_for_results();
		set_config(5, RST_FAST_PERIOD, RST_OPEN_THRESHOLD, RST_SHORT_THRESHOLD, RST_MIN_BLINKS);
		repeat (3)
			send_tick(make_tick(1, 0, 0, 1000, 1000, BAT_NORMAL));
		wait_for_results();
		// zero period: the timer fires on every tick
		set_config(0, 0, RST_OPEN_THRESHOLD, RST_SHORT_THRESHOLD, RST_MIN_BLINKS);
		repeat (4)
			send_tick(make_tick(1, 0, 0, 1000, 1000, BAT_NORMAL));
		send_tick(make_tick(1, 0, 0, 100, 1000, BAT_NORMAL));
		send_tick(make_tick(0, 0, 0, 1000, 1000, BAT_NORMAL));
		send_tick(make_tick(0, 0, 0, 1000, 1000, BAT_UNDER));
		wait_for_results();
	endtask

	// hazard at period 1 and min_blinks 255 runs the blink count into its ceiling
	task automatic test_count_saturation();
		idle_pct  = 0;
		stall_pct = 0;
		set_config(1, 1, RST_OPEN_THRESHOLD, RST_SHORT_THRESHOLD, 8'd255);
		send_tick(make_tick(1, 1, 0, 1000, 1000, BAT_NORMAL));
		send_tick(make_tick(0, 0, 0, 1000, 1000, BAT_NORMAL));
		send_tick(make_tick(0, 0, 1, 1000, 1000, BAT_NORMAL));
		repeat (520)
			send_tick(make_tick(0, 0, 0, 1000, 1000, BAT_NORMAL));
		send_tick(make_tick(0, 0, 1, 1000, 1000, BAT_NORMAL));
		wait_for_results();
		set_config(1, 1, RST_OPEN_THRESHOLD, RST_SHORT_THRESHOLD, 8'd254);
		send_tick(make_tick(0, 0, 0, 1000, 1000, BAT_NORMAL));
		wait_for_results();
	endtask

	task automatic test_directed();
		idle_pct  = 0;
		stall_pct = 0;
		set_config(4, 2, RST_OPEN_THRESHOLD, RST_SHORT_THRESHOLD, 1);
		send_tick(make_tick(0, 0, 0, 1000, 1000, BAT_NORMAL));
		send_tick(make_tick(0, 0, 1, 1000, 1000, BAT_NORMAL));
		// faults and battery are ignored while in hazard
		send_tick(make_tick(0, 0, 1, 0, 4095, BAT_UNDER));
		repeat (4)
			send_tick(make_tick(0, 0, 0, 1000, 1000, BAT_NORMAL));
		send_tick(make_tick(1, 0, 0, 1000, 1000, BAT_NORMAL));
		send_tick(make_tick(1, 0, 0, 1000, 1000, BAT_NORMAL));
		send_tick(make_tick(1, 1, 0, 1000, 1000, BAT_NORMAL));
		send_tick(make_tick(0, 1, 0, 1000, 1000, BAT_NORMAL));
		send_tick(make_tick(0, 1, 0, 619, 2483, BAT_NORMAL));
		send_tick(make_tick(0, 1, 0, 620, 2482, BAT_NORMAL));
		// both shorted leaves the period selection alone
		send_tick(make_tick(0, 0, 0, 4095, 4095, BAT_NORMAL));
		send_tick(make_tick(0, 0, 0, 1000, 1000, BAT_OVER));
		send_tick(make_tick(1, 0, 0, 1000, 1000, BAT_UNDER));
		send_tick(make_tick(1, 0, 0, 1000, 1000, BAT_RESERVED));
		send_tick(make_tick(0, 0, 0, 0, 1000, BAT_RESERVED));
		send_tick(make_tick(1, 0, 0, 0, 0, BAT_NORMAL));
		repeat (3)
			send_tick(make_tick(1, 0, 0, 1000, 1000, BAT_NORMAL));
		send_tick(make_tick(1, 0, 1, 1000, 1000, BAT_NORMAL));
		send_tick(make_tick(1, 0, 0, 1000, 1000, BAT_NORMAL));
		send_tick(make_tick(0, 0, 1, 1000, 1000, BAT_OVER));
		wait_for_results();
	endtask

	// held switch runs with random lamp currents, hazard presses and some noise
	task automatic test_random_traffic(input int count, input int send_idle, recv_stall,
			input bit with_hold);
		tick_t t;
		int    run_len;
		logic  l_lvl, r_lvl;
		idle_pct  = send_idle;
		stall_pct = recv_stall;
		run_len   = 0;
		l_lvl     = 1'b0;
		r_lvl     = 1'b0;
		for (int i = 0; i < count; i++) begin
			if (with_hold && i == count / 2)
				hold_req = 1'b1;
			if (run_len == 0) begin
				run_len = $urandom_range(25, 1);
				case ($urandom_range(9))
				0, 1, 2, 3: {l_lvl, r_lvl} = 2'b00;
				4, 5:       {l_lvl, r_lvl} = 2'b10;
				6, 7:       {l_lvl, r_lvl} = 2'b01;
				default:    {l_lvl, r_lvl} = 2'($urandom_range(3));
				endcase
			end
			run_len--;
			if ($urandom_range(9) == 0) begin
				t.left_sw   = 1'($urandom_range(1));
				t.right_sw  = 1'($urandom_range(1));
				t.haz_sw    = 1'($urandom_range(1));
				t.left_cur  = CUR_W'($urandom_range(4095));
				t.right_cur = CUR_W'($urandom_range(4095));
				t.battery   = 2'($urandom_range(3));
			end else begin
				t.left_sw   = l_lvl;
				t.right_sw  = r_lvl;
				t.haz_sw    = ($urandom_range(7) == 0);
				t.left_cur  = pick_current();
				t.right_cur = pick_current();
				t.battery   = ($urandom_range(99) < 92) ? BAT_NORMAL : 2'($urandom_range(3, 1));
			end
			send_tick(t);
		end
		wait_for_results();
	endtask

	initial begin
		reset_model();
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_period_change();
		test_count_saturation();
		test_directed();

		set_config(3, 1, RST_OPEN_THRESHOLD, RST_SHORT_THRESHOLD, 1);
		test_random_traffic(100, 0, 0, 1'b1);
		set_config(255, 255, 0, 12'hFFF, 0);
		test_random_traffic(80, 66, 0, 1'b0);
		set_config(2, 1, 1500, 1600, 2);
		test_random_traffic(90, 0, 66, 1'b0);
		set_config(1, 3, 300, 3800, 4);
		test_random_traffic(100, 7, 7, 1'b0);
		// inverted thresholds: every sample is a fault
		set_config(6, 2, 12'hFFF, 0, 0);
		test_random_traffic(80, 0, 66, 1'b0);

		repeat (8)
			@(posedge clk);
		if (fail_count == 0 && pending_status.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
